[src/gblur_pkg.sv]
// gblur_pkg: shared constants, kernel weights and register codes for the 5x5 blur
// used by the channel interfaces and the gaussian_blur_5x5 top level
package gblur_pkg;

   localparam int PIX_W         = 8;
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int CFG_WIDTH_W   = 11;
   localparam int CFG_HEIGHT_W  = 13;
   localparam int CSR_DATA_W    = 13;
   localparam int RESET_WIDTH   = 1024;
   localparam int RESET_HEIGHT  = 1024;
   localparam int MAX_HEIGHT    = 4096;
   localparam int IN_ROW_W      = 13;
   localparam int IN_ROW_LIMIT  = 8191;
   localparam int OUT_ROW_W     = 12;

   localparam int KERNEL_TAPS   = 5;
   localparam int LINE_COUNT    = KERNEL_TAPS - 1;
   localparam int SEL_W         = 2;

   // fixed-point reciprocal of the kernel norm, exact for every reachable sum
   localparam int DIVISOR       = 159;
   localparam int RECIP_SHIFT   = 23;
   localparam int RECIP_MULT    = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
   localparam int ROW_SUM_W     = 14;
   localparam int SUM_W         = 16;
   localparam int PROD_W        = 32;

   localparam int FIFO_DEPTH    = 8;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [3:0] KERNEL_WEIGHT [KERNEL_TAPS][KERNEL_TAPS] = '{
      '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
      '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
      '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
      '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
      '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
   };

endpackage

[src/gblur_if.sv]
// gblur_if: valid/ready channel interfaces for pixel words, result words and csr writes
// depends on gblur_pkg for field widths and the register index type
interface gblur_req_if import gblur_pkg::*;;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_in;
   logic             flush;

   modport source (output valid, pixel_in, flush, input ready);
   modport sink (input valid, pixel_in, flush, output ready);
endinterface

interface gblur_rsp_if import gblur_pkg::*;;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] blurred_pixel;
   logic             frame_last;

   modport source (output valid, blurred_pixel, frame_last, input ready);
   modport sink (input valid, blurred_pixel, frame_last, output ready);
endinterface

interface gblur_csr_if import gblur_pkg::*;;
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/gaussian_blur_5x5.sv]
// gaussian_blur_5x5: streaming 5x5 integer gaussian blur over raster-order 8-bit frames
// depends on gblur_pkg and the channel interfaces in gblur_if.sv
//
// usage
//  - req_chan takes one word per cycle while req_chan.ready is high: a pixel in raster
//    order, or a flush word that stands for a zero pixel; after the width*height pixels
//    of a frame send 2*width+2 flush words to push the last rows out
//  - rsp_chan gives one blurred pixel per word once its window is complete, so the
//    first result of a frame follows the (2*width+3)th word; frame_last marks the
//    final pixel of the frame, after which the next word starts a new frame
//  - csr_chan writes frame_width (index 0) and frame_height (index 1); write only
//    while the block is idle; csr_chan.ready is always high
//  - pipeline: the word that completes a window passes bank read, window shift, row
//    sums, total, reciprocal multiply and the result fifo before its result is offered
//  - throughput: one word per cycle while req_chan.ready is high, set by the single-port
//    line banks that are read and written once per word
//  - rsp stall: an 8-word result fifo decouples the sides; req_chan.ready drops only
//    when 8 results are outstanding
//  - reset: geometry returns to 1024x1024, counters and fifo clear; line banks need
//    no clearing since taps of rows not yet written are masked to zero
module gaussian_blur_5x5 import gblur_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input logic         clock,
   input logic         reset,
   gblur_req_if.sink   req_chan,
   gblur_rsp_if.source rsp_chan,
   gblur_csr_if.sink   csr_chan
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int EW     = $clog2(MAX_WIDTH + 1);
   localparam int WCMP_W = (EW > CFG_WIDTH_W) ? EW : CFG_WIDTH_W;
   localparam int RCMP_W = CFG_HEIGHT_W + 1;
   localparam int CCMP_W = EW + 1;
   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic                   emit;
      logic                   last;
      logic [KERNEL_TAPS-1:0] row_ok;
      logic [KERNEL_TAPS-1:0] col_ok;
   } step_ctrl_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } rsp_word_type;

   // ---------------------------------------------------------------- csr registers
   logic [CFG_WIDTH_W-1:0]  frame_width_ff;
   logic [CFG_HEIGHT_W-1:0] frame_height_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_WIDTH_W'(RESET_WIDTH);
         frame_height_ff <= CFG_HEIGHT_W'(RESET_HEIGHT);
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_chan.data[CFG_WIDTH_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_chan.data[CFG_HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // geometry clamped into the supported range
   logic [EW-1:0]           eff_w;
   logic [CFG_HEIGHT_W-1:0] eff_h;

   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = EW'(1);
      end else if (WCMP_W'(frame_width_ff) > WCMP_W'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         eff_h = CFG_HEIGHT_W'(1);
      end else if (frame_height_ff > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
         eff_h = CFG_HEIGHT_W'(MAX_HEIGHT);
      end else begin
         eff_h = frame_height_ff;
      end
   end

   // ---------------------------------------------------------------- stream position
   logic [COL_W-1:0]     in_col_ff, in_col_in;
   logic [IN_ROW_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [OUT_ROW_W-1:0] out_row_ff, out_row_in;
   logic [CNT_W-1:0]     pend_ff, pend_in;

   logic             acc;
   logic             step_emit;
   logic             step_last;
   logic [EW-1:0]    in_col_inc;
   logic [EW-1:0]    out_col_inc;
   logic [PIX_W-1:0] pix_wr;

   assign req_chan.ready = (pend_ff < CNT_W'(FIFO_DEPTH));
   assign acc            = req_chan.valid & req_chan.ready;
   assign pix_wr         = req_chan.flush ? '0 : req_chan.pixel_in;
   assign in_col_inc     = EW'(in_col_ff) + EW'(1);
   assign out_col_inc    = EW'(out_col_ff) + EW'(1);

   // window of the next output is complete once 2*width+2 words of the frame arrived
   assign step_emit = (in_row_ff >= IN_ROW_W'(4))
                   || (in_row_ff == IN_ROW_W'(3) && eff_w >= EW'(2))
                   || (in_row_ff == IN_ROW_W'(2) && in_col_ff >= COL_W'(2));

   // final pixel of the frame, or an output row already past the frame
   assign step_last = (CFG_HEIGHT_W'(out_row_ff) >= eff_h - CFG_HEIGHT_W'(1)
                       && EW'(out_col_ff) >= eff_w - EW'(1))
                   || (CFG_HEIGHT_W'(out_row_ff) >= eff_h);

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (acc) begin
         if (in_col_inc >= eff_w) begin
            in_col_in = '0;
            if (in_row_ff != IN_ROW_W'(IN_ROW_LIMIT)) begin
               in_row_in = in_row_ff + IN_ROW_W'(1);
            end
         end else begin
            in_col_in = in_col_inc[COL_W-1:0];
         end
         if (step_emit) begin
            if (step_last) begin
               // frame done, next word opens a new frame
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_inc >= eff_w) begin
               out_col_in = '0;
               out_row_in = out_row_ff + OUT_ROW_W'(1);
            end else begin
               out_col_in = out_col_inc[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // tap masks for the output pixel of this step: taps outside the frame read zero
   step_ctrl_type s0_ctrl;
   logic [RCMP_W-1:0] row_pos [KERNEL_TAPS];
   logic [CCMP_W-1:0] col_pos [KERNEL_TAPS];

   always_comb begin
      s0_ctrl.emit = step_emit;
      s0_ctrl.last = step_last;
      for (int j = 0; j < KERNEL_TAPS; j++) begin
         // offsets are biased by the kernel radius
         row_pos[j] = RCMP_W'(out_row_ff) + RCMP_W'(j);
         col_pos[j] = CCMP_W'(out_col_ff) + CCMP_W'(j);
         s0_ctrl.row_ok[j] = (row_pos[j] >= RCMP_W'(2))
                          && (row_pos[j] < RCMP_W'(eff_h) + RCMP_W'(2));
         s0_ctrl.col_ok[j] = (col_pos[j] >= CCMP_W'(2))
                          && (col_pos[j] < CCMP_W'(eff_w) + CCMP_W'(2));
      end
   end

   // ---------------------------------------------------------------- line banks
   // bank n holds the rows whose index is n modulo 4; the bank of the incoming row
   // still holds the row four above it, read before it is overwritten
   logic [PIX_W-1:0] bank_rd_ff [LINE_COUNT];

   for (genvar b = 0; b < LINE_COUNT; b++) begin : g_bank
      logic [PIX_W-1:0] bank_ff [MAX_WIDTH];

      always_ff @(posedge clock) begin
         if (acc) begin
            bank_rd_ff[b] <= bank_ff[in_col_ff];
            if (in_row_ff[SEL_W-1:0] == SEL_W'(b)) begin
               bank_ff[in_col_ff] <= pix_wr;
            end
         end
      end
   end

   // stage 1: bank read data and the new pixel
   logic              s1_valid_ff;
   step_ctrl_type     s1_ctrl_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [SEL_W-1:0]  s1_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= acc;
      end
      if (acc) begin
         s1_ctrl_ff <= s0_ctrl;
         s1_pix_ff  <= pix_wr;
         s1_sel_ff  <= in_row_ff[SEL_W-1:0];
      end
   end

   // column of five vertically adjacent pixels, newest row first
   logic [PIX_W-1:0] col_vec [KERNEL_TAPS];

   always_comb begin
      col_vec[0] = s1_pix_ff;
      for (int k = 1; k < KERNEL_TAPS; k++) begin
         col_vec[k] = bank_rd_ff[SEL_W'(s1_sel_ff - SEL_W'(k))];
      end
   end

   // stage 2: 5x5 window, slot 0 oldest column
   logic [PIX_W-1:0] win_ff [KERNEL_TAPS][KERNEL_TAPS];
   logic             s2_valid_ff;
   step_ctrl_type    s2_ctrl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         s2_ctrl_ff <= s1_ctrl_ff;
         for (int s = 0; s < KERNEL_TAPS - 1; s++) begin
            win_ff[s] <= win_ff[s + 1];
         end
         win_ff[KERNEL_TAPS-1] <= col_vec;
      end
   end

   // stage 3: weighted row sums with out-of-frame taps masked
   logic [ROW_SUM_W-1:0] row_sum_in [KERNEL_TAPS];
   logic [ROW_SUM_W-1:0] row_sum_ff [KERNEL_TAPS];
   logic                 s3_valid_ff;
   logic                 s3_last_ff;

   always_comb begin
      for (int k = 0; k < KERNEL_TAPS; k++) begin
         row_sum_in[k] = '0;
         for (int s = 0; s < KERNEL_TAPS; s++) begin
            if (s2_ctrl_ff.row_ok[KERNEL_TAPS-1-k] && s2_ctrl_ff.col_ok[s]) begin
               row_sum_in[k] = row_sum_in[k]
                  + ROW_SUM_W'(win_ff[s][k])
                  * ROW_SUM_W'(KERNEL_WEIGHT[KERNEL_TAPS-1-k][s]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff & s2_ctrl_ff.emit;
      end
      row_sum_ff <= row_sum_in;
      s3_last_ff <= s2_ctrl_ff.last;
   end

   // stage 4: total weighted sum
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] sum_ff;
   logic             s4_valid_ff;
   logic             s4_last_ff;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < KERNEL_TAPS; k++) begin
         sum_in = sum_in + SUM_W'(row_sum_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      sum_ff     <= sum_in;
      s4_last_ff <= s3_last_ff;
   end

   // stage 5: divide by the kernel norm through the reciprocal
   logic [PROD_W-1:0] prod_ff;
   logic              s5_valid_ff;
   logic              s5_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      prod_ff    <= PROD_W'(sum_ff) * PROD_W'(RECIP_MULT);
      s5_last_ff <= s4_last_ff;
   end

   // ---------------------------------------------------------------- result fifo
   rsp_word_type     fifo_ff [FIFO_DEPTH];
   rsp_word_type     fifo_wr_word;
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_take;

   assign fifo_wr_word.pixel = prod_ff[RECIP_SHIFT +: PIX_W];
   assign fifo_wr_word.last  = s5_last_ff;
   assign rsp_take           = rsp_chan.valid & rsp_chan.ready;

   assign rsp_chan.valid         = (cnt_ff != '0);
   assign rsp_chan.blurred_pixel = fifo_ff[rd_ptr_ff].pixel;
   assign rsp_chan.frame_last    = fifo_ff[rd_ptr_ff].last;

   // pend counts every result owed from acceptance until delivery, so the fifo
   // can never overflow while the pipeline itself never stalls
   always_comb begin
      pend_in = pend_ff;
      if (acc && step_emit) begin
         pend_in = pend_in + CNT_W'(1);
      end
      if (rsp_take) begin
         pend_in = pend_in - CNT_W'(1);
      end
      cnt_in = cnt_ff;
      if (s5_valid_ff) begin
         cnt_in = cnt_in + CNT_W'(1);
      end
      if (rsp_take) begin
         cnt_in = cnt_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         pend_ff   <= '0;
      end else begin
         if (s5_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= fifo_wr_word;
      end
   end

`ifndef SYNTHESIS
   // results in the fifo are always among those still owed
   a_fifo_within_pend: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= pend_ff)
      else $error("result fifo holds more words than are outstanding");

   // credit limit keeps outstanding results within the fifo
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= CNT_W'(FIFO_DEPTH))
      else $error("outstanding results exceed fifo depth");

   // the final pixel of a frame rewinds all stream counters
   a_frame_rewind: assert property (@(posedge clock) disable iff (reset)
      (acc && step_emit && step_last)
      |=> (in_col_ff == '0 && in_row_ff == '0 && out_col_ff == '0 && out_row_ff == '0))
      else $error("counters not cleared after the last pixel of a frame");
`endif

endmodule

[tb/sv/testbench.sv]
// testbench: checks gaussian_blur_5x5 against a cycle-free 5x5 blur predictor with random
// frame geometry, random source gaps and sink stalls; needs gblur_pkg and gblur_if.sv
`timescale 1ns / 1ps

module testbench import gblur_pkg::*;;

   // predictor geometry and limits
   localparam int LINE_MAX      = 1024;
   localparam int RING_DEPTH    = 4 * LINE_MAX + 5;
   localparam int HEIGHT_CAP    = 4096;
   localparam int ROW_CAP       = 8191;
   localparam int KERNEL_NORM   = 159;
   localparam int SETTLE_CYCLES = 16;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int RANDOM_WORDS  = 500;

   localparam int BLUR_WEIGHT [0:4][0:4] = '{
      '{2, 4,  5,  4,  2},
      '{4, 9,  12, 9,  4},
      '{5, 12, 15, 12, 5},
      '{4, 9,  12, 9,  4},
      '{2, 4,  5,  4,  2}
   };

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             flush;
   } pix_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] blurred;
      logic             last_of_frame;
   } blurred_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gblur_req_if req_chan ();
   gblur_rsp_if rsp_chan ();
   gblur_csr_if csr_chan ();

   gaussian_blur_5x5 #(
      .MAX_WIDTH (LINE_MAX)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // words waiting to be sent, results waiting to arrive
   pix_word_type     pix_pending_q[$];
   blurred_word_type blurred_q[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;

   // handshake flags captured at the rising edge, used by the falling-edge drivers
   logic req_word_taken = 1'b0;
   logic rsp_word_taken = 1'b0;

   // predictor state: geometry registers, pixel ring, stream and output positions
   logic [CFG_WIDTH_W-1:0]  geo_width  = CFG_WIDTH_W'(RESET_WIDTH);
   logic [CFG_HEIGHT_W-1:0] geo_height = CFG_HEIGHT_W'(RESET_HEIGHT);
   logic [PIX_W-1:0]        blur_ring [RING_DEPTH];
   int unsigned             in_col  = 0;
   int unsigned             in_row  = 0;
   int unsigned             out_col = 0;
   int unsigned             out_row = 0;

   // advance the blur stream by one word; returns 1 when an output pixel leaves
   function automatic bit blur_next_result(input logic [PIX_W-1:0] pixel,
                                           input logic flush,
                                           output blurred_word_type res);
      int unsigned w;
      int unsigned h;
      int unsigned pos;
      int unsigned out_pos;
      int unsigned sum;
      int          rr;
      int          cc;
      bit          last;
      res = '0;
      // registers are used saturated into their legal range
      w = (geo_width == 0) ? 1 : ((geo_width > LINE_MAX) ? LINE_MAX : geo_width);
      h = (geo_height == 0) ? 1 : ((geo_height > HEIGHT_CAP) ? HEIGHT_CAP : geo_height);
      pos     = in_row * w + in_col;
      out_pos = out_row * w + out_col;

      // flush words inside the frame stand for zero, anything past the last row is dropped
      if (in_row < h)
         blur_ring[pos % RING_DEPTH] = flush ? '0 : pixel;

      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         if (in_row < ROW_CAP)
            in_row++;
      end

      // window of the next output pixel not complete yet
      if (pos < out_pos + 2 * w + 2)
         return 1'b0;

      sum = 0;
      for (int dr = -2; dr <= 2; dr++) begin
         for (int dc = -2; dc <= 2; dc++) begin
            rr = int'(out_row) + dr;
            cc = int'(out_col) + dc;
            // taps off the frame edge count as zero
            if (rr >= 0 && cc >= 0 && rr < int'(h) && cc < int'(w))
               sum += blur_ring[(rr * w + cc) % RING_DEPTH] * BLUR_WEIGHT[dr + 2][dc + 2];
         end
      end
      last = (out_row >= h - 1 && out_col >= w - 1) || out_row >= h;
      res.blurred       = PIX_W'(sum / KERNEL_NORM);
      res.last_of_frame = last;

      // final pixel of the frame puts every position back to the frame start
      if (last) begin
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit blur_frame_idle();
      return in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0;
   endfunction

   // per-word wait drawn at random, with occasional stretches of no waiting at all
   function automatic int unsigned draw_wait(inout bit calm);
      if ($urandom_range(0, 47) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, 13);
   endfunction

   task automatic flag_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // sample handshakes, run the predictor on accepted pixel words, check result words
   always @(posedge clock) begin
      blurred_word_type want;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         cycle_count++;
         req_word_taken <= !reset && req_chan.valid && req_chan.ready;
         rsp_word_taken <= !reset && rsp_chan.valid && rsp_chan.ready;

         if (!reset && req_chan.valid && req_chan.ready) begin
            if (blur_next_result(req_chan.pixel_in, req_chan.flush, want))
               blurred_q.push_back(want);
         end

         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (blurred_q.size() == 0) begin
               flag_mismatch($sformatf("result word %0d/%0b with nothing expected",
                                       rsp_chan.blurred_pixel, rsp_chan.frame_last));
            end else begin
               want = blurred_q.pop_front();
               if (rsp_chan.blurred_pixel !== want.blurred)
                  flag_mismatch($sformatf("blurred_pixel got %0d want %0d",
                                          rsp_chan.blurred_pixel, want.blurred));
               if (rsp_chan.frame_last !== want.last_of_frame)
                  flag_mismatch($sformatf("frame_last got %0b want %0b",
                                          rsp_chan.frame_last, want.last_of_frame));
            end
         end
      end
   end

   // pixel word driver: holds a word until taken, then waits its drawn gap
   int unsigned send_gap  = 0;
   bit          send_calm = 1'b0;

   always @(negedge clock) begin
      pix_word_type nxt;
      if (!reset) begin
         if (req_chan.valid && !req_word_taken) begin
            // word still on the channel, keep it there
         end else if (send_gap != 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (pix_pending_q.size() != 0) begin
            nxt = pix_pending_q.pop_front();
            req_chan.pixel_in <= nxt.pixel;
            req_chan.flush    <= nxt.flush;
            req_chan.valid    <= 1'b1;
            send_gap = draw_wait(send_calm);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result sink: stalls a drawn number of cycles after every result word
   int unsigned sink_stall = 0;
   bit          sink_calm  = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_word_taken)
            sink_stall = draw_wait(sink_calm);
         if (sink_stall != 0) begin
            sink_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic push_word(input logic [PIX_W-1:0] pixel, input logic flush);
      pix_word_type word;
      word.pixel = pixel;
      word.flush = flush;
      pix_pending_q.push_back(word);
   endtask

   // one register write on the csr channel, mirrored into the predictor when taken
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      csr_chan.valid <= 1'b1;
      @(posedge clock);
      while (!csr_chan.ready)
         @(posedge clock);
      if (idx == CSR_FRAME_WIDTH)
         geo_width = value[CFG_WIDTH_W-1:0];
      else
         geo_height = value[CFG_HEIGHT_W-1:0];
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] w_data,
                               input logic [CSR_DATA_W-1:0] h_data);
      write_reg(CSR_FRAME_WIDTH, w_data);
      write_reg(CSR_FRAME_HEIGHT, h_data);
   endtask

   // queue one frame plus its flush tail; noisy frames get flush words inside the frame,
   // pixel words past the frame and tails that are cut short or run long
   task automatic queue_frame(input int unsigned w, input int unsigned h, input bit noisy,
                              output int unsigned sent);
      int unsigned tail;
      sent = 0;
      for (int unsigned k = 0; k < w * h; k++) begin
         push_word(PIX_W'($urandom_range(0, 255)), noisy && $urandom_range(0, 15) == 0);
         sent++;
      end
      tail = 2 * w + 2;
      if (noisy && $urandom_range(0, 7) == 0)
         tail = $urandom_range(0, 3 * w + 1);
      for (int unsigned k = 0; k < tail; k++) begin
         push_word(PIX_W'($urandom_range(0, 255)), !(noisy && $urandom_range(0, 3) == 0));
         sent++;
      end
   endtask

   task automatic wait_sent();
      while (pix_pending_q.size() != 0 || req_chan.valid)
         @(posedge clock);
   endtask

   // let the stream run dry, close any frame left open with flush words, then let
   // the pipeline drain before the next register write
   task automatic settle_stream();
      wait_sent();
      while (!blur_frame_idle()) begin
         push_word('0, 1'b1);
         wait_sent();
      end
      while (blurred_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned random_sent;
      int unsigned sent;
      int unsigned w;
      int unsigned h;
      int unsigned frames;

      foreach (blur_ring[k])
         blur_ring[k] = '0;
      req_chan.valid    = 1'b0;
      req_chan.pixel_in = '0;
      req_chan.flush    = 1'b0;
      rsp_chan.ready    = 1'b0;
      csr_chan.valid    = 1'b0;
      csr_chan.index    = CSR_FRAME_WIDTH;
      csr_chan.data     = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 3x3 frame: full-scale and zero pixels, a flush word inside the frame,
      // pixel words in the tail that must be treated as flushes
      set_geometry(CSR_DATA_W'(3), CSR_DATA_W'(3));
      push_word(8'd255, 1'b0); push_word(8'd255, 1'b0); push_word(8'd255, 1'b0);
      push_word(8'd255, 1'b0); push_word(8'd0, 1'b0);   push_word(8'd255, 1'b0);
      push_word(8'd0, 1'b0);   push_word(8'd255, 1'b0); push_word(8'hA5, 1'b1);
      push_word(8'hFF, 1'b1);  push_word(8'd255, 1'b0); push_word(8'd0, 1'b1);
      push_word(8'd0, 1'b0);   push_word(8'h5A, 1'b1);  push_word(8'd0, 1'b1);
      push_word(8'd200, 1'b0); push_word(8'd0, 1'b1);
      settle_stream();

      // zero in both registers saturates to a 1x1 frame
      set_geometry('0, '0);
      push_word(8'd255, 1'b0);
      push_word(8'd255, 1'b0); push_word(8'd0, 1'b1);
      push_word(8'hFF, 1'b1);  push_word(8'd17, 1'b0);
      settle_stream();

      // data bits above the width register are dropped, leaving a 3-wide frame
      set_geometry(CSR_DATA_W'('h1803), CSR_DATA_W'(2));
      queue_frame(3, 2, 1'b0, sent);
      settle_stream();

      // random geometry, mostly small frames, a few frames back to back per setting
      random_sent = 0;
      while (random_sent < RANDOM_WORDS) begin
         w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         set_geometry(CSR_DATA_W'(w), CSR_DATA_W'(h));
         frames = $urandom_range(1, 3);
         for (int unsigned f = 0; f < frames; f++) begin
            queue_frame(w, h, 1'b1, sent);
            random_sent += sent;
         end
         settle_stream();
      end

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
